[hw/rtl/rgb2yuv_pkg.sv]
// Shared widths, coefficients and reset values for the RGB to YUV 4:2:0 converter.
package rgb2yuv_pkg;

    localparam int COMP_W                 = 8;
    localparam int LINE_WIDTH_W           = 13;
    localparam int PIX_DATA_W             = 3 * COMP_W;
    localparam int DEFAULT_MAX_LINE_WIDTH = 4096;
    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd1920;

    // signed width of the coefficient sums
    localparam int SUM_W = 18;

    localparam logic signed [SUM_W-1:0] Y_R  = 18'sd66;
    localparam logic signed [SUM_W-1:0] Y_G  = 18'sd129;
    localparam logic signed [SUM_W-1:0] Y_B  = 18'sd25;
    localparam logic signed [SUM_W-1:0] CB_R = -18'sd38;
    localparam logic signed [SUM_W-1:0] CB_G = -18'sd74;
    localparam logic signed [SUM_W-1:0] CB_B = 18'sd112;
    localparam logic signed [SUM_W-1:0] CR_R = 18'sd112;
    localparam logic signed [SUM_W-1:0] CR_G = -18'sd94;
    localparam logic signed [SUM_W-1:0] CR_B = -18'sd18;

    localparam logic [COMP_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [COMP_W-1:0] CHROMA_OFFSET = 8'd128;

    localparam logic [COMP_W-1:0] LUMA_MIN   = 8'd16;
    localparam logic [COMP_W-1:0] LUMA_MAX   = 8'd235;
    localparam logic [COMP_W-1:0] CHROMA_MIN = 8'd16;
    localparam logic [COMP_W-1:0] CHROMA_MAX = 8'd240;

endpackage

[hw/rtl/rgb_to_yuv420_subsampler.sv]
// Streaming BGR to YUV 4:2:0 converter, BT.601 studio range, point-sampled chroma.
//
//  channel | direction | tdata (low bit up)                 | tuser
//  --------+-----------+------------------------------------+--------------
//  s_      | in        | blue[7:0] green[15:8] red[23:16]    | frame_start
//  m_      | out       | luma[7:0] cb[15:8] cr[23:16]        | chroma_valid
//  cfg_    | in        | line_width[12:0]                   | -
//
// One pixel per clock sustained while m_tready is high; two register stages, input and
// output, each registered. Column and line-parity state advance at the input transfer.
// m_tready stalls propagate back to s_tready only once both stages hold data.
// Synchronous active-low reset empties the pipeline and sets line_width to 1920.
module rgb_to_yuv420_subsampler
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = DEFAULT_MAX_LINE_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PIX_DATA_W-1:0]   s_tdata,    // blue, green, red
    input  logic                    s_tuser,    // frame_start
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [PIX_DATA_W-1:0]   m_tdata,    // luma, chroma_blue, chroma_red
    output logic                    m_tuser,    // chroma_valid
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LINE_WIDTH_W-1:0] cfg_data    // line_width
);

    localparam int COL_W  = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int FULL_W = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CNT_W  = (FULL_W > LINE_WIDTH_W) ? FULL_W : LINE_WIDTH_W;
    localparam logic [CNT_W-1:0] MAX_W    = CNT_W'(MAX_LINE_WIDTH);
    localparam logic [CNT_W-1:0] MAX_EVEN = MAX_W & ~CNT_W'(1);
    localparam logic [CNT_W-1:0] MIN_W    = CNT_W'(2);

    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [COL_W-1:0]        col_reg, col_next, col_cur;
    logic                    odd_reg, odd_next, odd_cur;
    logic [CNT_W-1:0]        width_raw, width_eff, col_inc;
    logic                    s_xfer, advance, wrap;

    logic                    in_valid_reg;
    logic [COMP_W-1:0]       in_blue_reg, in_green_reg, in_red_reg;
    logic                    in_cvalid_reg;

    logic                    out_valid_reg;
    logic [COMP_W-1:0]       out_luma_reg, out_cb_reg, out_cr_reg;
    logic                    out_cvalid_reg;

    logic signed [SUM_W-1:0] r_s, g_s, b_s;
    logic signed [SUM_W-1:0] y_sum, cb_sum, cr_sum;
    logic signed [SUM_W-1:0] y_shr, cb_shr, cr_shr;
    logic [COMP_W-1:0]       luma_next, cb_next, cr_next;

    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    // line width: even, at least 2, at most MAX_LINE_WIDTH rounded down to even
    always_comb begin
        width_raw = CNT_W'({line_width_reg[LINE_WIDTH_W-1:1], 1'b0});
        if (width_raw < MIN_W) begin
            width_eff = MIN_W;
        end else if (width_raw > MAX_W) begin
            width_eff = MAX_EVEN;
        end else begin
            width_eff = width_raw;
        end
    end

    always_comb begin
        col_cur  = s_tuser ? '0 : col_reg;
        odd_cur  = s_tuser ? 1'b0 : odd_reg;
        col_inc  = CNT_W'(col_cur) + CNT_W'(1);
        wrap     = (col_inc >= width_eff);
        col_next = wrap ? '0 : COL_W'(col_inc);
        odd_next = wrap ? !odd_cur : odd_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RESET;
            col_reg        <= '0;
            odd_reg        <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_width_reg <= cfg_data;
            end
            if (s_xfer) begin
                col_reg <= col_next;
                odd_reg <= odd_next;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_blue_reg   <= s_tdata[COMP_W-1:0];
            in_green_reg  <= s_tdata[2*COMP_W-1:COMP_W];
            in_red_reg    <= s_tdata[3*COMP_W-1:2*COMP_W];
            in_cvalid_reg <= !odd_cur && !col_cur[0];
        end
    end

    always_comb begin
        r_s    = $signed({{(SUM_W-COMP_W){1'b0}}, in_red_reg});
        g_s    = $signed({{(SUM_W-COMP_W){1'b0}}, in_green_reg});
        b_s    = $signed({{(SUM_W-COMP_W){1'b0}}, in_blue_reg});
        y_sum  = Y_R * r_s + Y_G * g_s + Y_B * b_s;
        cb_sum = CB_R * r_s + CB_G * g_s + CB_B * b_s;
        cr_sum = CR_R * r_s + CR_G * g_s + CR_B * b_s;
        y_shr  = y_sum >>> 8;
        cb_shr = cb_sum >>> 8;
        cr_shr = cr_sum >>> 8;
        luma_next = y_shr[COMP_W-1:0] + LUMA_OFFSET;
        cb_next   = in_cvalid_reg ? cb_shr[COMP_W-1:0] + CHROMA_OFFSET : '0;
        cr_next   = in_cvalid_reg ? cr_shr[COMP_W-1:0] + CHROMA_OFFSET : '0;
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_luma_reg   <= luma_next;
            out_cb_reg     <= cb_next;
            out_cr_reg     <= cr_next;
            out_cvalid_reg <= in_cvalid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cr_reg, out_cb_reg, out_luma_reg};
    assign m_tuser  = out_cvalid_reg;

endmodule

[hw/rtl/rgb2yuv_checker.sv]
// Port-level checks for the RGB to YUV 4:2:0 converter, bound to the top level.
module rgb2yuv_checker
    import rgb2yuv_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [PIX_DATA_W-1:0]   m_tdata,
    input logic                    m_tuser
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_luma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:0] >= LUMA_MIN && m_tdata[7:0] <= LUMA_MAX)
        else $error("luma out of range");

    a_chroma_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[15:8] >= CHROMA_MIN && m_tdata[15:8] <= CHROMA_MAX &&
            m_tdata[23:16] >= CHROMA_MIN && m_tdata[23:16] <= CHROMA_MAX)
        else $error("chroma out of range");

    a_chroma_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == '0)
        else $error("chroma not cleared without chroma sample");

endmodule

bind rgb_to_yuv420_subsampler rgb2yuv_checker u_rgb2yuv_checker (.*);
